### sv/assert_macros.svh
// Assertion macros used by the top level of the weighted pick block.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define CHK_IMPLY(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define CHK_ALWAYS(name, cond)
`define CHK_IMPLY(name, pre, post)
`endif
`endif

### sv/wpc_pkg.sv
// Package for the weighted pick with cooldown block: sizes, codes, structs.
// No dependencies.
`timescale 1ns / 1ps
package wpc_pkg;
  localparam int MAX_SLOTS    = 32;
  localparam int IDX_W        = $clog2(MAX_SLOTS);
  localparam int CNT_W        = 6;
  localparam int WEIGHT_SCALE = 100;
  localparam int SUM_W        = $clog2(MAX_SLOTS * 255 * WEIGHT_SCALE + 1);
  localparam int FRAC_W       = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PICK = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [4:0]  slot;
    logic [7:0]  slot_weight;
    logic [19:0] slot_interval_ms;
    logic [31:0] time_now_ms;
    logic [15:0] random_fraction;
  } req_t;

  typedef struct packed {
    logic       picked;
    logic [4:0] picked_index;
  } rsp_t;

  // token that walks the row of cells
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] acc;
  } chain_t;

  // broadcast control for all cells
  typedef struct packed {
    logic             pick_pass;
    logic [31:0]      now;
    logic [SUM_W-1:0] choice;
  } ctl_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  weight;
    logic [19:0] interval;
  } load_t;
endpackage

### sv/weighted_pick_with_cooldown_top.sv
// Top level of the weighted pick with cooldown block.
// Depends on wpc_pkg, wpc_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Roulette-wheel pick over MAX_SLOTS slots, each in a cell of a row. A load
// transfer writes one slot and answers picked 0. A pick walks a token down
// the row twice: once to sum weight*100 over eligible slots, then, after the
// multiply state that forms the choice, once more to find the first slot
// whose running sum passes the choice; if no slot is eligible, it answers
// picked 0 after the first walk. The token walks one cell per cycle. One
// item is in flight at a time; the response register lets the next request
// transfer in the cycle its predecessor's response leaves.
module weighted_pick_with_cooldown_top import wpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);
  typedef enum logic [1:0] {S_IDLE, S_TOTAL, S_MUL, S_PICK} state_t;

  state_t                  state;
  logic [CNT_W-1:0]        entry_count;
  logic [CNT_W-1:0]        count_eff;
  logic [31:0]             now_q;
  logic [FRAC_W-1:0]       frac_q;
  logic [SUM_W-1:0]        total;
  logic [SUM_W-1:0]        choice;
  logic [FRAC_W+SUM_W-1:0] product;
  logic                    pick_pass;
  chain_t                  launch;
  chain_t                  links [MAX_SLOTS+1];
  ctl_t                    ctl;
  logic                    req_fire;
  logic                    rsp_set;
  logic                    launch_go;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;

  // a response is produced by a load, an empty total, or the end of the pick pass
  assign rsp_set = (req_fire && (req.opcode == OP_LOAD)) ||
                   ((state == S_TOTAL) && links[MAX_SLOTS].valid &&
                    (links[MAX_SLOTS].acc == '0)) ||
                   ((state == S_PICK) && links[MAX_SLOTS].valid);

  // start a token walk for the total pass and again for the pick pass
  assign launch_go = (req_fire && (req.opcode == OP_PICK)) || (state == S_MUL);

  // clamp entry count to the table size
  assign count_eff = (entry_count > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : entry_count;

  assign product = (FRAC_W+SUM_W)'(frac_q) * (FRAC_W+SUM_W)'(total);

  assign ctl.pick_pass = pick_pass;
  assign ctl.now       = now_q;
  assign ctl.choice    = choice;

  assign links[0] = launch;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    load_t ld;
    assign ld.en       = req_fire && (req.opcode == OP_LOAD) && (32'(req.slot) == i);
    assign ld.weight   = req.slot_weight;
    assign ld.interval = req.slot_interval_ms;
    wpc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .active   (CNT_W'(i) < count_eff),
      .ld       (ld),
      .ctl      (ctl),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      launch      <= '0;
      entry_count <= '0;
      pick_pass   <= 1'b0;
    end else begin
      // the token payload stays zero; only its valid bit moves
      launch.valid <= launch_go;
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
      // raise the response, or drop it once taken
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.opcode == OP_LOAD) begin
              rsp <= '0;
            end else begin
              now_q     <= req.time_now_ms;
              frac_q    <= req.random_fraction;
              pick_pass <= 1'b0;
              state     <= S_TOTAL;
            end
          end
        end
        S_TOTAL: begin
          if (links[MAX_SLOTS].valid) begin
            total <= links[MAX_SLOTS].acc;
            if (links[MAX_SLOTS].acc == '0) begin
              rsp   <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // choice = frac * total >> 16, always below total
          choice    <= product[FRAC_W+SUM_W-1:FRAC_W];
          pick_pass <= 1'b1;
          state     <= S_PICK;
        end
        S_PICK: begin
          if (links[MAX_SLOTS].valid) begin
            rsp.picked       <= links[MAX_SLOTS].hit;
            rsp.picked_index <= 5'(links[MAX_SLOTS].idx);
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK_ALWAYS(a_tail_in_pass, !links[MAX_SLOTS].valid || state == S_TOTAL || state == S_PICK)
  `CHK_IMPLY(a_choice_below_total, state == S_PICK, choice < total)
  `CHK_IMPLY(a_index_in_range, rsp_valid && rsp.picked, CNT_W'(rsp.picked_index) < count_eff)
endmodule

### sv/wpc_cell.sv
// One slot cell of the weighted pick row: holds weight, interval, next time.
// Depends on wpc_pkg.
`timescale 1ns / 1ps
module wpc_cell import wpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  logic             active,
  input  load_t            ld,
  input  ctl_t             ctl,
  input  chain_t           link_in,
  output chain_t           link_out
);
  logic [7:0]       weight;
  logic [19:0]      interval;
  logic [31:0]      next_time;
  logic             eligible;
  logic [SUM_W-1:0] term;
  logic [SUM_W-1:0] sum;
  logic             take;
  chain_t           link_out_next;

  always_comb begin
    eligible = active && (weight != 8'd0) && (next_time <= ctl.now);
    term     = eligible ? SUM_W'(weight) * SUM_W'(WEIGHT_SCALE) : '0;
    sum      = link_in.acc + term;
    take     = ctl.pick_pass && !link_in.hit && eligible && (ctl.choice < sum);
    link_out_next       = link_in;
    link_out_next.acc   = sum;
    link_out_next.hit   = link_in.hit | take;
    link_out_next.idx   = take ? idx : link_in.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight         <= '0;
      interval       <= '0;
      next_time      <= '0;
      link_out.valid <= 1'b0;
    end else begin
      if (ld.en) begin
        weight    <= ld.weight;
        interval  <= ld.interval;
        next_time <= '0;
      end else if (link_in.valid && take) begin
        next_time <= ctl.now + 32'(interval);
      end
      link_out <= link_out_next;
    end
  end
endmodule
